// ----- rtl/complex_arith_unit_assert.svh -----
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAU_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAU_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package cau_pkg;
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_NEG   = 3'd4,
    OP_RECIP = 3'd5
  } op_e;
endpackage

// ----- rtl/complex_arith_unit.sv -----
// ----------------------------------------------------------------------------
// complex_arith_unit
// Pipelined fixed point complex add, subtract, multiply, divide, negate and
// reciprocal with round-to-nearest and saturation.
// ----------------------------------------------------------------------------
// Pipeline: WORD_BITS+6 register stages (input, product, sum, prepare,
//   WORD_BITS+1 divider bit stages, output register).
//   Every operation takes the same path.
// Throughput: one transfer per cycle while not stalled; the divider is one
//   restoring bit stage per quotient bit; a stall freezes the whole pipe.
// Reset: clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`include "complex_arith_unit_assert.svh"
module complex_arith_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  req_type_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic                        zero_divisor_o,
  output logic                        saturated_o
);

  localparam int WB = WORD_BITS;
  localparam int FB = FRAC_BITS;
  // operand width: holds every input word and the exact reciprocal numerator
  localparam int OW = ((WB > FB + 1) ? WB : FB + 1) + 1;
  localparam int PW = 2 * OW;        // product
  localparam int XW = PW + 2;        // sums, rounded products
  localparam int QB = WB + 1;        // quotient bits kept
  localparam int MW = XW + FB + 1;   // dividend
  localparam int CW = MW + QB;       // divider compare

  localparam logic [XW-1:0] HALF = ({{(XW-1){1'b0}}, 1'b1} << FB) >> 1;
  localparam logic signed [XW-1:0] MAXX = {{(XW-WB+1){1'b0}}, {(WB-1){1'b1}}};
  localparam logic signed [XW-1:0] MINX = {{(XW-WB+1){1'b1}}, {(WB-1){1'b0}}};
  localparam logic [WB-1:0] MAXW = {1'b0, {(WB-1){1'b1}}};
  localparam logic [WB-1:0] MINW = {1'b1, {(WB-1){1'b0}}};
  localparam logic [QB-1:0] QMAXP = {2'b00, {(WB-1){1'b1}}};
  localparam logic [QB-1:0] QMAXN = {2'b01, {(WB-1){1'b0}}};

  typedef struct packed {
    logic          is_div;
    logic          zd;
    logic          ovf_re;
    logic          ovf_im;
    logic          neg_re;
    logic          neg_im;
    logic [MW-1:0] r_re;
    logic [MW-1:0] r_im;
    logic [PW:0]   d2;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
    logic [WB-1:0] c_re;
    logic [WB-1:0] c_im;
    logic          c_sat;
  } div_t;

  // saturate a wide signed value: {sat, word}
  function automatic logic [WB:0] clip_x(input logic signed [XW-1:0] x);
    logic [WB:0] r;
    if (x > MAXX) r = {1'b1, MAXW};
    else if (x < MINX) r = {1'b1, MINW};
    else r = {1'b0, x[WB-1:0]};
    return r;
  endfunction

  // signed quotient to word: {sat, word}
  function automatic logic [WB:0] fin_q(input logic neg, input logic ovf,
                                        input logic [QB-1:0] q);
    logic [WB:0]   r;
    logic [QB-1:0] nq;
    nq = -q;
    if (!neg) r = (ovf || q > QMAXP) ? {1'b1, MAXW} : {1'b0, q[WB-1:0]};
    else      r = (ovf || q > QMAXN) ? {1'b1, MINW} : {1'b0, nq[WB-1:0]};
    return r;
  endfunction

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- stage 0: operand capture, reciprocal swap
  logic                 v0_q;
  logic [2:0]           op0_q;
  logic signed [OW-1:0] ar0_q, ai0_q, br0_q, bi0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (en) v0_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op0_q <= req_type_i;
      if (req_type_i == cau_pkg::OP_RECIP) begin
        ar0_q <= OW'(1) << FB;
        ai0_q <= '0;
        br0_q <= OW'(a_re_i);
        bi0_q <= OW'(a_im_i);
      end else begin
        ar0_q <= OW'(a_re_i);
        ai0_q <= OW'(a_im_i);
        br0_q <= OW'(b_re_i);
        bi0_q <= OW'(b_im_i);
      end
    end
  end

  // ---------------- stage 1: partial products
  logic                 v1_q;
  logic [2:0]           op1_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, p_bb_q, p_cc_q;
  logic signed [OW-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= v0_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= op0_q;
      p_rr_q <= ar0_q * br0_q;
      p_ii_q <= ai0_q * bi0_q;
      p_ri_q <= ar0_q * bi0_q;
      p_ir_q <= ai0_q * br0_q;
      p_bb_q <= br0_q * br0_q;
      p_cc_q <= bi0_q * bi0_q;
      ar1_q  <= ar0_q;
      ai1_q  <= ai0_q;
      br1_q  <= br0_q;
      bi1_q  <= bi0_q;
    end
  end

  // ---------------- stage 2: sums and |b|^2
  logic                 v2_q;
  logic [2:0]           op2_q;
  logic signed [XW-1:0] s_re_q, s_im_q;
  logic [PW-1:0]        den_q;
  logic signed [XW-1:0] s_re_d, s_im_d;

  always_comb begin
    case (op1_q) inside
      cau_pkg::OP_ADD: begin
        s_re_d = XW'(ar1_q) + XW'(br1_q);
        s_im_d = XW'(ai1_q) + XW'(bi1_q);
      end
      cau_pkg::OP_SUB: begin
        s_re_d = XW'(ar1_q) - XW'(br1_q);
        s_im_d = XW'(ai1_q) - XW'(bi1_q);
      end
      cau_pkg::OP_NEG: begin
        s_re_d = -XW'(ar1_q);
        s_im_d = -XW'(ai1_q);
      end
      cau_pkg::OP_MUL: begin
        s_re_d = XW'(p_rr_q) - XW'(p_ii_q);
        s_im_d = XW'(p_ri_q) + XW'(p_ir_q);
      end
      cau_pkg::OP_DIV, cau_pkg::OP_RECIP: begin
        s_re_d = XW'(p_rr_q) + XW'(p_ii_q);
        s_im_d = XW'(p_ir_q) - XW'(p_ri_q);
      end
      default: begin
        s_re_d = '0;
        s_im_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      op2_q  <= op1_q;
      s_re_q <= s_re_d;
      s_im_q <= s_im_d;
      den_q  <= $unsigned(p_bb_q) + $unsigned(p_cc_q);
    end
  end

  // ---------------- stage 3: rounding / clip, or divider setup
  logic [QB:0] vq;
  div_t        dq [QB+1];
  div_t        d3_d;

  always_comb begin
    logic          neg_r, neg_i;
    logic [XW-1:0] mag_r, mag_i, m_r, m_i;
    logic signed [XW-1:0] val_r, val_i;
    logic [WB:0]   cl_r, cl_i;
    logic [MW-1:0] mm_r, mm_i;
    logic [PW:0]   d2;
    neg_r = s_re_q[XW-1];
    neg_i = s_im_q[XW-1];
    mag_r = neg_r ? -s_re_q : s_re_q;
    mag_i = neg_i ? -s_im_q : s_im_q;
    m_r   = (mag_r + HALF) >> FB;
    m_i   = (mag_i + HALF) >> FB;
    val_r = (op2_q == cau_pkg::OP_MUL) ? (neg_r ? -m_r : m_r) : s_re_q;
    val_i = (op2_q == cau_pkg::OP_MUL) ? (neg_i ? -m_i : m_i) : s_im_q;
    cl_r  = clip_x(val_r);
    cl_i  = clip_x(val_i);
    d2    = {den_q, 1'b0};
    mm_r  = (MW'(mag_r) << (FB + 1)) + MW'(den_q);
    mm_i  = (MW'(mag_i) << (FB + 1)) + MW'(den_q);
    d3_d.is_div = (op2_q == cau_pkg::OP_DIV) || (op2_q == cau_pkg::OP_RECIP);
    d3_d.zd     = d3_d.is_div && (den_q == '0);
    d3_d.ovf_re = CW'(mm_r) >= (CW'(d2) << QB);
    d3_d.ovf_im = CW'(mm_i) >= (CW'(d2) << QB);
    d3_d.neg_re = neg_r;
    d3_d.neg_im = neg_i;
    d3_d.r_re   = mm_r;
    d3_d.r_im   = mm_i;
    d3_d.d2     = d2;
    d3_d.q_re   = '0;
    d3_d.q_im   = '0;
    d3_d.c_re   = cl_r[WB-1:0];
    d3_d.c_im   = cl_i[WB-1:0];
    d3_d.c_sat  = cl_r[WB] | cl_i[WB];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vq[0] <= 1'b0;
    else if (en) vq[0] <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) dq[0] <= d3_d;
  end

  // ---------------- restoring divider, one quotient bit per stage, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int BI = QB - 1 - k;
    div_t st_d;

    always_comb begin
      logic [CW-1:0] dd;
      dd   = CW'(dq[k].d2) << BI;
      st_d = dq[k];
      if (CW'(dq[k].r_re) >= dd) begin
        st_d.r_re     = dq[k].r_re - dd[MW-1:0];
        st_d.q_re[BI] = 1'b1;
      end
      if (CW'(dq[k].r_im) >= dd) begin
        st_d.r_im     = dq[k].r_im - dd[MW-1:0];
        st_d.q_im[BI] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vq[k+1] <= 1'b0;
      else if (en) vq[k+1] <= vq[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) dq[k+1] <= st_d;
    end
  end

  // ---------------- output register
  logic [WB-1:0] res_re_q, res_im_q;
  logic          zd_q, sat_q;
  logic [WB:0]   f_re, f_im;

  assign f_re = fin_q(dq[QB].neg_re, dq[QB].ovf_re, dq[QB].q_re);
  assign f_im = fin_q(dq[QB].neg_im, dq[QB].ovf_im, dq[QB].q_im);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= vq[QB];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!dq[QB].is_div) begin
        res_re_q <= dq[QB].c_re;
        res_im_q <= dq[QB].c_im;
        zd_q     <= 1'b0;
        sat_q    <= dq[QB].c_sat;
      end else if (dq[QB].zd) begin
        res_re_q <= '0;
        res_im_q <= '0;
        zd_q     <= 1'b1;
        sat_q    <= 1'b0;
      end else begin
        res_re_q <= f_re[WB-1:0];
        res_im_q <= f_im[WB-1:0];
        zd_q     <= 1'b0;
        sat_q    <= f_re[WB] | f_im[WB];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign res_re_o       = res_re_q;
  assign res_im_o       = res_im_q;
  assign zero_divisor_o = zd_q;
  assign saturated_o    = sat_q;

  // ---------------- assertions
  `CAU_ASSERT(a_zd_nosat, clk_i, rst_ni, (out_valid_q && zd_q) |-> !sat_q, "zero divisor with saturation")
  `CAU_ASSERT(a_zd_zero, clk_i, rst_ni, (out_valid_q && zd_q) |-> (res_re_q == '0 && res_im_q == '0), "zero divisor result not zero")
  `CAU_ASSERT(a_sat_lim, clk_i, rst_ni, (out_valid_q && sat_q) |-> (res_re_q == MAXW || res_re_q == MINW || res_im_q == MAXW || res_im_q == MINW), "saturation without limit value")

endmodule
